@@ src/tbeq_pkg.sv @@
// Shared constants, control types and the sequencer program of the three-band equaliser.
`timescale 1ns / 1ps

package tbeq_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int POLE_WIDTH_DEF   = 32;

    localparam int COEF_W     = 17;
    localparam int GAIN_W     = 15;
    localparam int COEF_FRAC  = 16;
    localparam int GAIN_FRAC  = 12;
    localparam int SEC_W      = 2;
    localparam int NUM_SECTIONS = 2 ** SEC_W;
    localparam int HIST_DEPTH = 3;
    localparam int STEP_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_COEF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_COEF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN = 3'd4;

    localparam logic [COEF_W-1:0] LOW_COEF_RST  = 17'd7545;
    localparam logic [COEF_W-1:0] HIGH_COEF_RST = 17'd42131;
    localparam logic [GAIN_W-1:0] GAIN_RST      = 15'd4096;

    // Operand register sources
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_DIFF = 3'd1;
    localparam logic [2:0] OP_LOW  = 3'd2;
    localparam logic [2:0] OP_MID  = 3'd3;
    localparam logic [2:0] OP_HIGH = 3'd4;

    // Multiply-accumulate actions
    localparam logic [1:0] MAC_NONE   = 2'd0;
    localparam logic [1:0] MAC_LO_CLR = 2'd1;
    localparam logic [1:0] MAC_LO_ADD = 2'd2;
    localparam logic [1:0] MAC_HI     = 2'd3;

    // Multiplier constant selection
    localparam logic [2:0] K_LOW_COEF  = 3'd0;
    localparam logic [2:0] K_HIGH_COEF = 3'd1;
    localparam logic [2:0] K_LOW_GAIN  = 3'd2;
    localparam logic [2:0] K_MID_GAIN  = 3'd3;
    localparam logic [2:0] K_HIGH_GAIN = 3'd4;

    // Jump conditions
    localparam logic [1:0] C_NONE     = 2'd0;
    localparam logic [1:0] C_WAIT_IN  = 2'd1;
    localparam logic [1:0] C_SEC_MORE = 2'd2;
    localparam logic [1:0] C_WAIT_OUT = 2'd3;

    localparam logic [STEP_W-1:0] S_IDLE      = 5'd0;
    localparam logic [STEP_W-1:0] S_LOW_LOOP  = 5'd2;
    localparam logic [STEP_W-1:0] S_HIGH_LOOP = 5'd7;
    localparam logic [STEP_W-1:0] S_OUT       = 5'd20;

    localparam logic CASC_LOW  = 1'b0;
    localparam logic CASC_HIGH = 1'b1;

    typedef struct packed {
        logic [2:0]        opnd_sel;
        logic [1:0]        mac;
        logic [2:0]        ksel;
        logic              casc;
        logic              prev_x;
        logic              pole_wr;
        logic [1:0]        cond;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic [2:0]       opnd_sel;
        logic [1:0]       mac;
        logic             casc;
        logic [SEC_W-1:0] sec;
        logic             prev_x;
        logic             pole_wr;
        logic             x_load;
        logic             hist_en;
    } dp_ctrl_t;

    function automatic ctrl_word_t mk_word(
        logic [2:0]        opnd_sel,
        logic [1:0]        mac,
        logic [2:0]        ksel,
        logic              casc,
        logic              prev_x,
        logic              pole_wr,
        logic [1:0]        cond,
        logic [STEP_W-1:0] target
    );
        ctrl_word_t w;
        w.opnd_sel = opnd_sel;
        w.mac      = mac;
        w.ksel     = ksel;
        w.casc     = casc;
        w.prev_x   = prev_x;
        w.pole_wr  = pole_wr;
        w.cond     = cond;
        w.target   = target;
        return w;
    endfunction

    // The program: two four-section cascades, then three band products summed.
    function automatic ctrl_word_t prog_rom(logic [STEP_W-1:0] step);
        ctrl_word_t w;
        case (step)
            5'd0:  w = mk_word(OP_NONE, MAC_NONE, K_LOW_COEF, CASC_LOW, 1'b0, 1'b0,
                               C_WAIT_IN, S_IDLE);
            5'd1:  w = mk_word(OP_NONE, MAC_NONE, K_LOW_COEF, CASC_LOW, 1'b1, 1'b0,
                               C_NONE, S_IDLE);
            5'd2:  w = mk_word(OP_DIFF, MAC_NONE, K_LOW_COEF, CASC_LOW, 1'b0, 1'b0,
                               C_NONE, S_IDLE);
            5'd3:  w = mk_word(OP_NONE, MAC_LO_CLR, K_LOW_COEF, CASC_LOW, 1'b0, 1'b0,
                               C_NONE, S_IDLE);
            5'd4:  w = mk_word(OP_NONE, MAC_HI, K_LOW_COEF, CASC_LOW, 1'b0, 1'b0,
                               C_NONE, S_IDLE);
            5'd5:  w = mk_word(OP_NONE, MAC_NONE, K_LOW_COEF, CASC_LOW, 1'b0, 1'b1,
                               C_SEC_MORE, S_LOW_LOOP);
            5'd6:  w = mk_word(OP_NONE, MAC_NONE, K_HIGH_COEF, CASC_HIGH, 1'b1, 1'b0,
                               C_NONE, S_IDLE);
            5'd7:  w = mk_word(OP_DIFF, MAC_NONE, K_HIGH_COEF, CASC_HIGH, 1'b0, 1'b0,
                               C_NONE, S_IDLE);
            5'd8:  w = mk_word(OP_NONE, MAC_LO_CLR, K_HIGH_COEF, CASC_HIGH, 1'b0, 1'b0,
                               C_NONE, S_IDLE);
            5'd9:  w = mk_word(OP_NONE, MAC_HI, K_HIGH_COEF, CASC_HIGH, 1'b0, 1'b0,
                               C_NONE, S_IDLE);
            5'd10: w = mk_word(OP_NONE, MAC_NONE, K_HIGH_COEF, CASC_HIGH, 1'b0, 1'b1,
                               C_SEC_MORE, S_HIGH_LOOP);
            5'd11: w = mk_word(OP_LOW, MAC_NONE, K_LOW_GAIN, CASC_LOW, 1'b0, 1'b0,
                               C_NONE, S_IDLE);
            5'd12: w = mk_word(OP_NONE, MAC_LO_CLR, K_LOW_GAIN, CASC_LOW, 1'b0, 1'b0,
                               C_NONE, S_IDLE);
            5'd13: w = mk_word(OP_NONE, MAC_HI, K_LOW_GAIN, CASC_LOW, 1'b0, 1'b0,
                               C_NONE, S_IDLE);
            5'd14: w = mk_word(OP_MID, MAC_NONE, K_MID_GAIN, CASC_LOW, 1'b0, 1'b0,
                               C_NONE, S_IDLE);
            5'd15: w = mk_word(OP_NONE, MAC_LO_ADD, K_MID_GAIN, CASC_LOW, 1'b0, 1'b0,
                               C_NONE, S_IDLE);
            5'd16: w = mk_word(OP_NONE, MAC_HI, K_MID_GAIN, CASC_LOW, 1'b0, 1'b0,
                               C_NONE, S_IDLE);
            5'd17: w = mk_word(OP_HIGH, MAC_NONE, K_HIGH_GAIN, CASC_LOW, 1'b0, 1'b0,
                               C_NONE, S_IDLE);
            5'd18: w = mk_word(OP_NONE, MAC_LO_ADD, K_HIGH_GAIN, CASC_LOW, 1'b0, 1'b0,
                               C_NONE, S_IDLE);
            5'd19: w = mk_word(OP_NONE, MAC_HI, K_HIGH_GAIN, CASC_LOW, 1'b0, 1'b0,
                               C_NONE, S_IDLE);
            5'd20: w = mk_word(OP_NONE, MAC_NONE, K_LOW_COEF, CASC_LOW, 1'b0, 1'b0,
                               C_WAIT_OUT, S_OUT);
            default: w = mk_word(OP_NONE, MAC_NONE, K_LOW_COEF, CASC_LOW, 1'b0, 1'b0,
                                 C_WAIT_IN, S_IDLE);
        endcase
        return w;
    endfunction

endpackage

@@ src/tbeq_datapath.sv @@
// Arithmetic datapath of the equaliser: pole and history state, shared multiplier, accumulator.
`timescale 1ns / 1ps

module tbeq_datapath #(
    parameter int SAMPLE_WIDTH = tbeq_pkg::SAMPLE_WIDTH_DEF,
    parameter int POLE_WIDTH   = tbeq_pkg::POLE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tbeq_pkg::dp_ctrl_t                   ctrl,
    input  logic        [SAMPLE_WIDTH-1:0]       x_in,
    input  logic        [tbeq_pkg::COEF_W-1:0]   k_in,
    output logic signed [SAMPLE_WIDTH-1:0]       result
);

    localparam int F     = (POLE_WIDTH > SAMPLE_WIDTH) ? (POLE_WIDTH - SAMPLE_WIDTH) : 0;
    localparam int DW    = POLE_WIDTH + 1;
    localparam int LO_W  = (DW > 33) ? 32 : (DW - 1);
    localparam int ACC_W = POLE_WIDTH + 20;
    localparam int MA_W  = LO_W + 1;
    localparam int MB_W  = tbeq_pkg::COEF_W + 1;
    localparam int PR_W  = MA_W + MB_W;
    localparam int OSH   = F + tbeq_pkg::GAIN_FRAC;

    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] hist_reg [tbeq_pkg::HIST_DEPTH];
    logic signed [POLE_WIDTH-1:0]   lp_reg [tbeq_pkg::NUM_SECTIONS];
    logic signed [POLE_WIDTH-1:0]   hp_reg [tbeq_pkg::NUM_SECTIONS];
    logic signed [POLE_WIDTH-1:0]   prev_reg;
    logic signed [DW-1:0]           opnd_reg;
    logic signed [DW-1:0]           opnd_next;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        acc_next;

    logic signed [POLE_WIDTH-1:0]   xp;
    logic signed [POLE_WIDTH-1:0]   dly;
    logic signed [POLE_WIDTH-1:0]   pole_cur;
    logic signed [POLE_WIDTH-1:0]   pole_new;
    logic signed [MA_W-1:0]         mul_a;
    logic signed [MB_W-1:0]         mul_b;
    logic signed [PR_W-1:0]         prod;
    logic signed [ACC_W-1:0]        prod_ext;

    function automatic logic signed [POLE_WIDTH-1:0] sat_pole(logic signed [ACC_W-1:0] v);
        logic signed [POLE_WIDTH-1:0] r;
        if (v[ACC_W-1:POLE_WIDTH-1] == {(ACC_W - POLE_WIDTH + 1){v[ACC_W-1]}})
        begin
            r = v[POLE_WIDTH-1:0];
        end
        else if (v[ACC_W-1])
        begin
            r = {1'b1, {(POLE_WIDTH - 1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(POLE_WIDTH - 1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_out(logic signed [ACC_W-1:0] v);
        logic signed [SAMPLE_WIDTH-1:0] r;
        if (v[ACC_W-1:SAMPLE_WIDTH-1] == {(ACC_W - SAMPLE_WIDTH + 1){v[ACC_W-1]}})
        begin
            r = v[SAMPLE_WIDTH-1:0];
        end
        else if (v[ACC_W-1])
        begin
            r = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
        end
        return r;
    endfunction

    always_comb
    begin
        xp       = sat_pole(ACC_W'(x_reg) <<< F);
        dly      = sat_pole(ACC_W'(hist_reg[tbeq_pkg::HIST_DEPTH-1]) <<< F);
        pole_cur = ctrl.casc ? hp_reg[ctrl.sec] : lp_reg[ctrl.sec];
    end

    always_comb
    begin
        case (ctrl.opnd_sel)
            tbeq_pkg::OP_DIFF: opnd_next = DW'(prev_reg) - DW'(pole_cur);
            tbeq_pkg::OP_LOW:  opnd_next = DW'(lp_reg[tbeq_pkg::NUM_SECTIONS-1]);
            tbeq_pkg::OP_MID:  opnd_next = DW'(hp_reg[tbeq_pkg::NUM_SECTIONS-1])
                                         - DW'(lp_reg[tbeq_pkg::NUM_SECTIONS-1]);
            tbeq_pkg::OP_HIGH: opnd_next = DW'(dly)
                                         - DW'(hp_reg[tbeq_pkg::NUM_SECTIONS-1]);
            default:           opnd_next = opnd_reg;
        endcase
    end

    // The operand is multiplied in two passes: the unsigned low part, then the signed high part.
    always_comb
    begin
        if (ctrl.mac == tbeq_pkg::MAC_HI)
        begin
            mul_a = MA_W'($signed(opnd_reg[DW-1:LO_W]));
        end
        else
        begin
            mul_a = $signed({1'b0, opnd_reg[LO_W-1:0]});
        end
        mul_b    = $signed({1'b0, k_in});
        prod     = mul_a * mul_b;
        prod_ext = ACC_W'(prod);
    end

    always_comb
    begin
        case (ctrl.mac)
            tbeq_pkg::MAC_LO_CLR: acc_next = prod_ext;
            tbeq_pkg::MAC_LO_ADD: acc_next = acc_reg + prod_ext;
            tbeq_pkg::MAC_HI:     acc_next = acc_reg + (prod_ext <<< LO_W);
            default:              acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        pole_new = sat_pole(ACC_W'(pole_cur) + (acc_reg >>> tbeq_pkg::COEF_FRAC));
        result   = sat_out(acc_reg >>> OSH);
    end

    always_ff @(posedge clk)
    begin
        opnd_reg <= opnd_next;
        acc_reg  <= acc_next;
        if (ctrl.x_load)
        begin
            x_reg <= $signed(x_in);
        end
        if (ctrl.prev_x)
        begin
            prev_reg <= xp;
        end
        else if (ctrl.pole_wr)
        begin
            prev_reg <= pole_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tbeq_pkg::NUM_SECTIONS; i++)
            begin
                lp_reg[i] <= '0;
                hp_reg[i] <= '0;
            end
            for (int i = 0; i < tbeq_pkg::HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctrl.pole_wr)
            begin
                if (ctrl.casc)
                begin
                    hp_reg[ctrl.sec] <= pole_new;
                end
                else
                begin
                    lp_reg[ctrl.sec] <= pole_new;
                end
            end
            if (ctrl.hist_en)
            begin
                hist_reg[0] <= x_reg;
                for (int i = 1; i < tbeq_pkg::HIST_DEPTH; i++)
                begin
                    hist_reg[i] <= hist_reg[i-1];
                end
            end
        end
    end

endmodule

@@ src/three_band_equalizer.sv @@
// Three-band equaliser top level: stream ports, configuration registers and the sequencer.
`timescale 1ns / 1ps

// Each sample is split into low, mid and high bands by two cascades of four one-pole
// lowpass sections, the bands are weighted by their Q3.12 gains and summed, and the sum is
// saturated to the sample width. A small microprogram steps one shared multiplier through
// the work: every pole update and every band product takes two multiplier passes, so one
// sample occupies the block from the transaction that brings it in to the cycle its
// result is registered, and the next sample is taken the cycle after that. The result
// sits in an output register, so a new sample is taken while it waits; the block stalls
// only when a second result is ready before the first has gone. Coefficients are unsigned
// Q1.16 values computed by software; write configuration only while idle.
module three_band_equalizer #(
    parameter int SAMPLE_WIDTH = tbeq_pkg::SAMPLE_WIDTH_DEF,
    parameter int POLE_WIDTH   = tbeq_pkg::POLE_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,  // sample_in
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] m_axis_tdata,  // sample_out
    input  logic                                    cfg_we,
    input  logic [tbeq_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [tbeq_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam logic [tbeq_pkg::SEC_W-1:0] LAST_SEC =
        tbeq_pkg::SEC_W'(tbeq_pkg::NUM_SECTIONS - 1);

    logic [tbeq_pkg::COEF_W-1:0] low_coef_reg;
    logic [tbeq_pkg::COEF_W-1:0] high_coef_reg;
    logic [tbeq_pkg::GAIN_W-1:0] low_gain_reg;
    logic [tbeq_pkg::GAIN_W-1:0] mid_gain_reg;
    logic [tbeq_pkg::GAIN_W-1:0] high_gain_reg;

    logic [tbeq_pkg::STEP_W-1:0] step_reg;
    logic [tbeq_pkg::STEP_W-1:0] step_next;
    logic [tbeq_pkg::SEC_W-1:0]  sec_reg;
    logic [tbeq_pkg::SEC_W-1:0]  sec_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [SAMPLE_WIDTH-1:0]     out_data_reg;

    tbeq_pkg::ctrl_word_t        word;
    tbeq_pkg::dp_ctrl_t          dp_ctrl;
    logic [tbeq_pkg::COEF_W-1:0] k_sel;
    logic signed [SAMPLE_WIDTH-1:0] dp_result;
    logic                        accept;
    logic                        fire;

    assign word          = tbeq_pkg::prog_rom(step_reg);
    assign s_axis_tready = (step_reg == tbeq_pkg::S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    // The closing step hands the result over once the output register is free.
    assign fire          = (word.cond == tbeq_pkg::C_WAIT_OUT)
                           && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'(out_data_reg);

    always_comb
    begin
        case (word.ksel)
            tbeq_pkg::K_LOW_COEF:  k_sel = low_coef_reg;
            tbeq_pkg::K_HIGH_COEF: k_sel = high_coef_reg;
            tbeq_pkg::K_LOW_GAIN:  k_sel = tbeq_pkg::COEF_W'(low_gain_reg);
            tbeq_pkg::K_MID_GAIN:  k_sel = tbeq_pkg::COEF_W'(mid_gain_reg);
            tbeq_pkg::K_HIGH_GAIN: k_sel = tbeq_pkg::COEF_W'(high_gain_reg);
            default:               k_sel = low_coef_reg;
        endcase
    end

    always_comb
    begin
        dp_ctrl.opnd_sel = word.opnd_sel;
        dp_ctrl.mac      = word.mac;
        dp_ctrl.casc     = word.casc;
        dp_ctrl.sec      = sec_reg;
        dp_ctrl.prev_x   = word.prev_x;
        dp_ctrl.pole_wr  = word.pole_wr;
        dp_ctrl.x_load   = accept;
        dp_ctrl.hist_en  = fire;
    end

    always_comb
    begin
        case (word.cond)
            tbeq_pkg::C_WAIT_IN:  step_next = accept ? (step_reg + 1'b1) : word.target;
            tbeq_pkg::C_SEC_MORE: step_next = (sec_reg != LAST_SEC) ? word.target
                                                                    : (step_reg + 1'b1);
            tbeq_pkg::C_WAIT_OUT: step_next = fire ? tbeq_pkg::S_IDLE : word.target;
            default:              step_next = step_reg + 1'b1;
        endcase
        // The section counter wraps back to zero after the last section of a cascade.
        sec_next = word.pole_wr ? (sec_reg + 1'b1) : sec_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= tbeq_pkg::S_IDLE;
            sec_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            sec_reg       <= sec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= dp_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_coef_reg  <= tbeq_pkg::LOW_COEF_RST;
            high_coef_reg <= tbeq_pkg::HIGH_COEF_RST;
            low_gain_reg  <= tbeq_pkg::GAIN_RST;
            mid_gain_reg  <= tbeq_pkg::GAIN_RST;
            high_gain_reg <= tbeq_pkg::GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tbeq_pkg::REG_LOW_COEF:  low_coef_reg  <= cfg_data[tbeq_pkg::COEF_W-1:0];
                tbeq_pkg::REG_HIGH_COEF: high_coef_reg <= cfg_data[tbeq_pkg::COEF_W-1:0];
                tbeq_pkg::REG_LOW_GAIN:  low_gain_reg  <= cfg_data[tbeq_pkg::GAIN_W-1:0];
                tbeq_pkg::REG_MID_GAIN:  mid_gain_reg  <= cfg_data[tbeq_pkg::GAIN_W-1:0];
                tbeq_pkg::REG_HIGH_GAIN: high_gain_reg <= cfg_data[tbeq_pkg::GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    tbeq_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .POLE_WIDTH   (POLE_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (dp_ctrl),
        .x_in   (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .k_in   (k_sel),
        .result (dp_result)
    );

endmodule
